/* hdl/idl2_pkg.sv */
`default_nettype none

package idl2_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int ACC_WIDTH   = 48;
   localparam int DIST_WIDTH  = 48;
   localparam int CODE_WIDTH  = 8;
   localparam int NIB_WIDTH   = CODE_WIDTH / 2;

   localparam int PROD_WIDTH  = NIB_WIDTH + VALUE_WIDTH;
   localparam int RECIP_WIDTH = 20;
   localparam int RECIP_SHIFT = 23;
   // ceil(2^23 / 15); exact floor(x / 15) for every x below 2^20
   localparam logic [RECIP_WIDTH-1:0] RECIP_15 = 20'd559241;
   localparam int RPROD_WIDTH = PROD_WIDTH + RECIP_WIDTH;

   localparam int DIFF_WIDTH  = VALUE_WIDTH + 3;
   localparam int MAG_WIDTH   = VALUE_WIDTH + 1;
   localparam int SQ_WIDTH    = 2 * MAG_WIDTH;

   typedef struct packed {
      logic load_in;
      logic sel_second;
      logic acc_en;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic second_valid;
      logic last_byte;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/idl2_datapath.sv */
`default_nettype none

module idl2_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  idl2_pkg::dp_cmd_type                  cmd,
   output idl2_pkg::dp_status_type               status,
   input  logic        [idl2_pkg::CODE_WIDTH-1:0]  req_code_byte,
   input  logic signed [idl2_pkg::VALUE_WIDTH-1:0] req_query_first,
   input  logic signed [idl2_pkg::VALUE_WIDTH-1:0] req_query_second,
   input  logic signed [idl2_pkg::VALUE_WIDTH-1:0] req_min_first,
   input  logic signed [idl2_pkg::VALUE_WIDTH-1:0] req_min_second,
   input  logic        [idl2_pkg::VALUE_WIDTH-1:0] req_range_first,
   input  logic        [idl2_pkg::VALUE_WIDTH-1:0] req_range_second,
   input  logic                                  req_second_valid,
   input  logic                                  req_last_byte,
   output logic        [idl2_pkg::DIST_WIDTH-1:0]  rsp_distance,
   output logic                                  rsp_overflowed
);
   import idl2_pkg::*;

   logic        [CODE_WIDTH-1:0]  code_ff;
   logic signed [VALUE_WIDTH-1:0] query_first_ff;
   logic signed [VALUE_WIDTH-1:0] query_second_ff;
   logic signed [VALUE_WIDTH-1:0] min_first_ff;
   logic signed [VALUE_WIDTH-1:0] min_second_ff;
   logic        [VALUE_WIDTH-1:0] range_first_ff;
   logic        [VALUE_WIDTH-1:0] range_second_ff;
   logic                          second_valid_ff;
   logic                          last_byte_ff;

   logic        [NIB_WIDTH-1:0]   nib;
   logic signed [VALUE_WIDTH-1:0] query_sel;
   logic signed [VALUE_WIDTH-1:0] min_sel;
   logic        [VALUE_WIDTH-1:0] range_sel;

   logic        [PROD_WIDTH-1:0]  prod_in;
   logic        [PROD_WIDTH-1:0]  prod_ff;
   logic        [RPROD_WIDTH-1:0] recip_prod;
   logic        [VALUE_WIDTH-1:0] quot_in;
   logic        [VALUE_WIDTH-1:0] quot_ff;
   logic signed [DIFF_WIDTH-1:0]  value_s;
   logic signed [DIFF_WIDTH-1:0]  diff_s;
   logic        [MAG_WIDTH-1:0]   mag_in;
   logic        [MAG_WIDTH-1:0]   mag_ff;
   logic        [SQ_WIDTH-1:0]    sq_in;
   logic        [SQ_WIDTH-1:0]    sq_ff;
   logic        [ACC_WIDTH:0]     sum_wide;
   logic        [ACC_WIDTH-1:0]   acc_ff;
   logic                          sat_ff;
   logic        [DIST_WIDTH-1:0]  distance_ff;
   logic                          overflowed_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         code_ff         <= req_code_byte;
         query_first_ff  <= req_query_first;
         query_second_ff <= req_query_second;
         min_first_ff    <= req_min_first;
         min_second_ff   <= req_min_second;
         range_first_ff  <= req_range_first;
         range_second_ff <= req_range_second;
         second_valid_ff <= req_second_valid;
         last_byte_ff    <= req_last_byte;
      end
   end

   assign status.second_valid = second_valid_ff;
   assign status.last_byte    = last_byte_ff;

   always_comb begin
      if (cmd.sel_second) begin
         nib       = code_ff[NIB_WIDTH-1:0];
         query_sel = query_second_ff;
         min_sel   = min_second_ff;
         range_sel = range_second_ff;
      end else begin
         nib       = code_ff[CODE_WIDTH-1:NIB_WIDTH];
         query_sel = query_first_ff;
         min_sel   = min_first_ff;
         range_sel = range_first_ff;
      end
   end

   assign prod_in    = PROD_WIDTH'(nib) * PROD_WIDTH'(range_sel);
   assign recip_prod = RPROD_WIDTH'(prod_ff) * RPROD_WIDTH'(RECIP_15);
   assign quot_in    = recip_prod[RECIP_SHIFT +: VALUE_WIDTH];

   always_comb begin
      value_s = DIFF_WIDTH'(signed'({1'b0, quot_ff})) + DIFF_WIDTH'(min_sel);
      diff_s  = DIFF_WIDTH'(query_sel) - value_s;
      if (diff_s[DIFF_WIDTH-1]) begin
         mag_in = MAG_WIDTH'(-diff_s);
      end else begin
         mag_in = MAG_WIDTH'(diff_s);
      end
   end

   assign sq_in    = SQ_WIDTH'(mag_ff) * SQ_WIDTH'(mag_ff);
   assign sum_wide = {1'b0, acc_ff} + (ACC_WIDTH + 1)'(sq_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      mag_ff  <= mag_in;
      sq_ff   <= sq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.acc_en) begin
         if (sum_wide[ACC_WIDTH]) begin
            acc_ff <= '1;
            sat_ff <= 1'b1;
         end else begin
            acc_ff <= sum_wide[ACC_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         distance_ff   <= acc_ff[DIST_WIDTH-1:0];
         overflowed_ff <= sat_ff;
      end
   end

   assign rsp_distance   = distance_ff;
   assign rsp_overflowed = overflowed_ff;

endmodule

`default_nettype wire

/* hdl/idl2_ctrl.sv */
`default_nettype none

module idl2_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output idl2_pkg::dp_cmd_type    cmd,
   input  idl2_pkg::dp_status_type status
);
   import idl2_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      MUL,
      DIV,
      DIFF,
      SQR,
      ACC,
      EMIT
   } state_type;

   state_type state_ff;
   logic      sel_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      rsp_free;

   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load_in    = accept;
   assign cmd.sel_second = sel_ff;
   assign cmd.acc_en     = (state_ff == ACC);
   assign cmd.load_rsp   = (state_ff == EMIT) && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  sel_ff   <= 1'b0;
                  state_ff <= MUL;
               end
            end
            MUL:  state_ff <= DIV;
            DIV:  state_ff <= DIFF;
            DIFF: state_ff <= SQR;
            SQR:  state_ff <= ACC;
            ACC: begin
               if (!sel_ff && status.second_valid) begin
                  sel_ff   <= 1'b1;
                  state_ff <= MUL;
               end else if (status.last_byte) begin
                  state_ff <= EMIT;
               end else begin
                  state_ff <= IDLE;
               end
            end
            EMIT: begin
               // hold until the result register is free
               if (rsp_free) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* hdl/int4_dequant_l2_distance.sv */
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   code byte, queries, mins, ranges, flags
// rsp_      out        rsp_valid/rsp_stall   distance, overflowed
//
// One shared lane runs five steps per dimension: nibble times range, reciprocal
// divide by 15, difference and magnitude, square, saturating accumulate.
// A second dimension runs the five steps again; a last byte adds the EMIT state
// to load the result register, and waits there while that register is stalled.
// Synchronous reset clears the accumulator, overflow flag and control state.
// The result register lets the next transaction enter while a result waits.
`default_nettype none

module int4_dequant_l2_distance (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic        [idl2_pkg::CODE_WIDTH-1:0]  req_code_byte,
   input  logic signed [idl2_pkg::VALUE_WIDTH-1:0] req_query_first,
   input  logic signed [idl2_pkg::VALUE_WIDTH-1:0] req_query_second,
   input  logic signed [idl2_pkg::VALUE_WIDTH-1:0] req_min_first,
   input  logic signed [idl2_pkg::VALUE_WIDTH-1:0] req_min_second,
   input  logic        [idl2_pkg::VALUE_WIDTH-1:0] req_range_first,
   input  logic        [idl2_pkg::VALUE_WIDTH-1:0] req_range_second,
   input  logic                                  req_second_valid,
   input  logic                                  req_last_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic        [idl2_pkg::DIST_WIDTH-1:0]  rsp_distance,
   output logic                                  rsp_overflowed
);
   import idl2_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   idl2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   idl2_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_code_byte    (req_code_byte),
      .req_query_first  (req_query_first),
      .req_query_second (req_query_second),
      .req_min_first    (req_min_first),
      .req_min_second   (req_min_second),
      .req_range_first  (req_range_first),
      .req_range_second (req_range_second),
      .req_second_valid (req_second_valid),
      .req_last_byte    (req_last_byte),
      .rsp_distance     (rsp_distance),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

`default_nettype wire

/* hdl/idl2_checker.sv */
`default_nettype none

module idl2_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [idl2_pkg::DIST_WIDTH-1:0]  rsp_distance,
   input logic                             rsp_overflowed
);
   import idl2_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("transaction accepted on back-to-back cycles");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   a_sat_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_distance == {DIST_WIDTH{1'b1}})
      else $error("overflowed result without saturated distance");

endmodule

bind int4_dequant_l2_distance idl2_checker u_checker (.*);

`default_nettype wire

/* tb/int4_dequant_l2_distance_test.sv */
`default_nettype none

module int4_dequant_l2_distance_test;

   import idl2_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HEAVY_VECTOR_BYTES = 40;
   localparam longint unsigned ACC_TOP = (64'd1 << ACC_WIDTH) - 1;

   typedef struct {
      logic [CODE_WIDTH-1:0]         code;
      logic signed [VALUE_WIDTH-1:0] query_first;
      logic signed [VALUE_WIDTH-1:0] query_second;
      logic signed [VALUE_WIDTH-1:0] min_first;
      logic signed [VALUE_WIDTH-1:0] min_second;
      logic [VALUE_WIDTH-1:0]        range_first;
      logic [VALUE_WIDTH-1:0]        range_second;
      logic                          second_valid;
      logic                          last_byte;
   } code_byte_type;

   typedef struct {
      logic [DIST_WIDTH-1:0] distance;
      logic                  overflowed;
   } distance_type;

   class l2_distance_tracker;
      longint unsigned running_sum;
      bit              saturated;
      distance_type    open_distances[$];
      int              errors;
      int              bytes_seen;
      int              vectors_done;
      int              sat_vectors;

      function void add_dimension(logic [NIB_WIDTH-1:0] nibble,
                                  logic signed [VALUE_WIDTH-1:0] query,
                                  logic signed [VALUE_WIDTH-1:0] minimum,
                                  logic [VALUE_WIDTH-1:0] span);
         longint level;
         longint diff;
         longint unsigned square;
         level = (longint'(nibble) * longint'(span)) / 15 + longint'(minimum);
         diff = longint'(query) - level;
         if (diff < 0) diff = -diff;
         square = longint'(diff) * longint'(diff);
         if (square > ACC_TOP - running_sum) begin
            running_sum = ACC_TOP;
            saturated = 1'b1;
         end else begin
            running_sum += square;
         end
      endfunction

      function void add_code_byte(code_byte_type b);
         distance_type done;
         bytes_seen++;
         add_dimension(b.code[CODE_WIDTH-1:NIB_WIDTH], b.query_first, b.min_first,
                       b.range_first);
         if (b.second_valid)
            add_dimension(b.code[NIB_WIDTH-1:0], b.query_second, b.min_second,
                          b.range_second);
         if (b.last_byte) begin
            done.distance = DIST_WIDTH'(running_sum);
            done.overflowed = saturated;
            open_distances.push_back(done);
            vectors_done++;
            if (saturated) sat_vectors++;
            running_sum = 0;
            saturated = 1'b0;
         end
      endfunction

      function void check_distance(logic [DIST_WIDTH-1:0] distance, logic overflowed);
         distance_type want;
         if (open_distances.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, distance %0h overflowed %0b",
                     $time, distance, overflowed);
            return;
         end
         want = open_distances.pop_front();
         if (distance !== want.distance) begin
            errors++;
            $display("%0t: distance expected %0h actual %0h", $time, want.distance, distance);
         end
         if (overflowed !== want.overflowed) begin
            errors++;
            $display("%0t: overflowed expected %0b actual %0b", $time, want.overflowed,
                     overflowed);
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [CODE_WIDTH-1:0]         req_code_byte = '0;
   logic signed [VALUE_WIDTH-1:0] req_query_first = '0;
   logic signed [VALUE_WIDTH-1:0] req_query_second = '0;
   logic signed [VALUE_WIDTH-1:0] req_min_first = '0;
   logic signed [VALUE_WIDTH-1:0] req_min_second = '0;
   logic [VALUE_WIDTH-1:0]        req_range_first = '0;
   logic [VALUE_WIDTH-1:0]        req_range_second = '0;
   logic                          req_second_valid = 1'b0;
   logic                          req_last_byte = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [DIST_WIDTH-1:0]         rsp_distance;
   logic                          rsp_overflowed;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stalled_cycles = 0;

   l2_distance_tracker board = new;

   int4_dequant_l2_distance i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .req_query_first  (req_query_first),
      .req_query_second (req_query_second),
      .req_min_first    (req_min_first),
      .req_min_second   (req_min_second),
      .req_range_first  (req_range_first),
      .req_range_second (req_range_second),
      .req_second_valid (req_second_valid),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_distance     (rsp_distance),
      .rsp_overflowed   (rsp_overflowed)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.add_code_byte('{req_code_byte, req_query_first, req_query_second,
                                  req_min_first, req_min_second, req_range_first,
                                  req_range_second, req_second_valid, req_last_byte});
         if (rsp_valid && !rsp_stall)
            board.check_distance(rsp_distance, rsp_overflowed);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      while (stalled_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("int4_dequant_l2_distance_test: done, errors");
      $finish;
   end

   task automatic send_code_byte(input code_byte_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_code_byte    <= b.code;
      req_query_first  <= b.query_first;
      req_query_second <= b.query_second;
      req_min_first    <= b.min_first;
      req_min_second   <= b.min_second;
      req_range_first  <= b.range_first;
      req_range_second <= b.range_second;
      req_second_valid <= b.second_valid;
      req_last_byte    <= b.last_byte;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_fields(input logic [CODE_WIDTH-1:0] code,
                              input logic [VALUE_WIDTH-1:0] qf, qs, mf, ms, rf, rs,
                              input logic sv, lb);
      send_code_byte('{code, qf, qs, mf, ms, rf, rs, sv, lb});
   endtask

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(7))
         0: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
         1: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
         2: return '0;
         3: return '1;
         default: return VALUE_WIDTH'($urandom);
      endcase
   endfunction

   task automatic send_random_byte(input logic last);
      send_fields(CODE_WIDTH'($urandom), pick_value(), pick_value(), pick_value(),
                  pick_value(), pick_value(), pick_value(), $urandom_range(4) != 0, last);
   endtask

   // hold the sender until every open vector has produced its distance
   task automatic drain_distances();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.open_distances.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_random_vectors(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++) send_random_byte(i == len - 1);
         sent += len;
         if ($urandom_range(24) == 0) drain_distances();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 7;
      recv_idle_pct = 64;

      send_fields(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  1'b1, 1'b1);
      send_fields(8'hFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                  1'b1, 1'b1);
      // odd tail: second-dimension fields are junk and must not count
      send_fields(8'hF7, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                  1'b0, 1'b1);
      send_fields(8'h12, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                  1'b1, 1'b0);
      send_fields(8'h8E, 16'h1234, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF,
                  1'b0, 1'b0);
      send_fields(8'h7F, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFE,
                  1'b1, 1'b1);
      send_fields(8'h11, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                  1'b1, 1'b1);
      send_fields(8'hEE, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h000F, 16'h000E,
                  1'b1, 1'b1);
      send_fields(8'h0F, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
                  1'b1, 1'b1);
      send_fields(8'hA5, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                  1'b0, 1'b0);
      send_fields(8'h5A, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                  1'b1, 1'b1);
      drain_distances();

      // worst-case squares over a long vector, then a clean vector
      for (int i = 0; i < HEAVY_VECTOR_BYTES; i++)
         send_fields(8'hFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                     1'b1, i == HEAVY_VECTOR_BYTES - 1);
      send_fields(8'h33, 16'h0100, 16'h0200, 16'h0000, 16'h0000, 16'h1000, 16'h1000,
                  1'b1, 1'b1);

      send_random_vectors(180);
      drain_distances();

      send_idle_pct = 64;
      recv_idle_pct = 7;
      send_random_vectors(180);
      drain_distances();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_vectors(180);
      drain_distances();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d code bytes in %0d vectors checked, %0d vectors saturated",
               board.bytes_seen, board.vectors_done, board.sat_vectors);
      $display("idle mixes: light sender with heavy stall, heavy sender gaps, back-to-back");
      if (board.errors == 0) begin
         $display("int4_dequant_l2_distance_test: done, clean");
      end else begin
         $display("int4_dequant_l2_distance_test: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
hdl/idl2_pkg.sv
hdl/idl2_datapath.sv
hdl/idl2_ctrl.sv
hdl/int4_dequant_l2_distance.sv
hdl/idl2_checker.sv
tb/int4_dequant_l2_distance_test.sv
